// File: hdl/assert_macros.svh
// Assertion macros for the spin lattice block.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge out of reset
`define SLM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a trigger implies a condition in the next cycle
`define SLM_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cond)) \
    else $error(msg);

`endif

// File: hdl/slm_pkg.sv
// Package for the spin lattice energy and magnetization block.
// Lattice sizes, field widths, line buffer types and helper functions; no dependencies.
`default_nettype none

package slm_pkg;

  // Lattice size, both powers of two
  localparam int ROWS = 64;
  localparam int COLS = 64;
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int COL_W = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int LOG_SITES = $clog2(ROWS * COLS);

  // Field widths
  localparam int COUPLING_W = 16;
  localparam int BOND_W = 15;
  localparam int ENERGY_W = 30;
  localparam int NET_W = 14;
  localparam int MAG_W = 16;
  localparam int FRAC_BITS = 14;
  localparam int PROD_W = COUPLING_W + BOND_W;
  localparam int MAG_FULL_W = NET_W + FRAC_BITS;

  localparam logic signed [COUPLING_W-1:0] COUPLING_RESET = 16'sd256;

  // Shift control for the line buffer chain
  typedef struct packed {
    logic en;
    logic load_first;
    logic spin;
  } slm_shift_t;

  // Bits held by one cell: previous row and first row
  typedef struct packed {
    logic row_bit;
    logic first_bit;
  } slm_tap_t;

  // Product of two spins coded as bits: +1 when alike, -1 when not
  function automatic logic signed [1:0] pair_product(input logic a, input logic b);
    return (a == b) ? 2'sd1 : -2'sd1;
  endfunction

endpackage

`default_nettype wire

// File: hdl/slm_cell.sv
// One column cell of the line buffer chain.
// Holds the previous row spin and the first row spin; uses slm_pkg.
`default_nettype none

module slm_cell (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  slm_pkg::slm_tap_t      tap_i,
  output slm_pkg::slm_tap_t      tap_o
);

  slm_pkg::slm_tap_t tap_q;

  // Advance both bits on every accepted spin
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_q <= '0;
    end else if (en_i) begin
      tap_q <= tap_i;
    end
  end

  assign tap_o = tap_q;

endmodule

`default_nettype wire

// File: hdl/slm_chain.sv
// Chain of COLS cells acting as the previous row and first row line buffers.
// Uses slm_pkg and slm_cell; the tail cell gives the spins of the current column.
`default_nettype none

module slm_chain (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  slm_pkg::slm_shift_t    shift_i,
  output slm_pkg::slm_tap_t      tail_o
);

  slm_pkg::slm_tap_t taps [slm_pkg::COLS];
  slm_pkg::slm_tap_t head;

  // Feed the head: new spin for the row line, load or recirculate the first row line
  always_comb begin
    head.row_bit   = shift_i.spin;
    head.first_bit = shift_i.load_first ? shift_i.spin : taps[slm_pkg::COLS-1].first_bit;
  end

  for (genvar i = 0; i < slm_pkg::COLS; i++) begin : g_cell
    slm_pkg::slm_tap_t cell_in;
    if (i == 0) begin : g_head
      assign cell_in = head;
    end else begin : g_body
      assign cell_in = taps[i-1];
    end
    slm_cell u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (shift_i.en),
      .tap_i (cell_in),
      .tap_o (taps[i])
    );
  end

  assign tail_o = taps[slm_pkg::COLS-1];

endmodule

`default_nettype wire

// File: hdl/spin_lattice_energy_magnetization.sv
// Top level: 2D periodic lattice bond sum, energy, net spin and magnetization.
// Uses slm_pkg, slm_chain (and slm_cell below it) and assert_macros.svh.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-----------------------------------
//  cfg     | in        | cfg_valid_i / cfg_ready_o | cfg_data_i (coupling, Q8.8)
//  in      | in        | in_valid_i / in_ready_o   | spin_up_i
//  out     | out       | out_valid_o / out_ready_i | bond_sum_o, energy_o, net_spin_o,
//          |           |                           | magnetization_o
//
// One spin is taken per cycle while in_ready_o is high; each one shifts the chain.
// After its last spin a frame result goes through stage A, which holds the sums,
// then through the coupling multiply into the output register.
// Reset clears the chain, counters and sums; coupling resets to 1.0.
// in_ready_o drops only on a last spin while an earlier result still waits.
`default_nettype none
`include "assert_macros.svh"

module spin_lattice_energy_magnetization (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  cfg_valid_i,
  output logic                                       cfg_ready_o,
  input  wire logic signed [slm_pkg::COUPLING_W-1:0] cfg_data_i,
  input  wire logic                                  in_valid_i,
  output logic                                       in_ready_o,
  input  wire logic                                  spin_up_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_ready_i,
  output logic signed [slm_pkg::BOND_W-1:0]          bond_sum_o,
  output logic signed [slm_pkg::ENERGY_W-1:0]        energy_o,
  output logic signed [slm_pkg::NET_W-1:0]           net_spin_o,
  output logic signed [slm_pkg::MAG_W-1:0]           magnetization_o
);

  logic signed [slm_pkg::COUPLING_W-1:0] coupling_q;
  logic [slm_pkg::COL_W-1:0]             col_q;
  logic [slm_pkg::ROW_W-1:0]             row_q;
  logic                                  prev_spin_q;
  logic                                  first_spin_q;
  logic signed [slm_pkg::BOND_W-1:0]     bond_acc_q, bond_acc_d;
  logic signed [slm_pkg::NET_W-1:0]      spin_acc_q, spin_acc_d;
  logic                                  a_valid_q;
  logic signed [slm_pkg::BOND_W-1:0]     a_bond_q;
  logic signed [slm_pkg::NET_W-1:0]      a_net_q;
  logic                                  out_valid_q;
  logic signed [slm_pkg::BOND_W-1:0]     bond_q;
  logic signed [slm_pkg::ENERGY_W-1:0]   energy_q, energy_d;
  logic signed [slm_pkg::NET_W-1:0]      net_q;
  logic signed [slm_pkg::MAG_W-1:0]      mag_q, mag_d;

  logic                  in_fire;
  logic                  a_move;
  logic                  col_first, col_last, row_first, row_last, last_site;
  logic signed [3:0]     delta;
  slm_pkg::slm_shift_t   shift;
  slm_pkg::slm_tap_t     tail;
  logic signed [slm_pkg::PROD_W-1:0]     prod;
  logic signed [slm_pkg::MAG_FULL_W-1:0] mag_full;
  logic                  frame_clear;
  logic                  held_back;

  // Coupling register, always ready
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coupling_q <= slm_pkg::COUPLING_RESET;
    end else if (cfg_valid_i) begin
      coupling_q <= cfg_data_i;
    end
  end

  // Position in the frame
  assign col_first = (col_q == '0);
  assign col_last  = (col_q == slm_pkg::COL_W'(slm_pkg::COLS - 1));
  assign row_first = (row_q == '0);
  assign row_last  = (row_q == slm_pkg::ROW_W'(slm_pkg::ROWS - 1));
  assign last_site = col_last && row_last;

  // Result handoff and input stall
  assign a_move     = a_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !(last_site && a_valid_q && !a_move);
  assign in_fire    = in_valid_i && in_ready_o;

  // Drive the line buffer chain
  always_comb begin
    shift.en         = in_fire;
    shift.load_first = row_first;
    shift.spin       = spin_up_i;
  end

  slm_chain u_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .shift_i(shift),
    .tail_o (tail)
  );

  // Bond contribution of this site: left, up, row wrap and column wrap
  always_comb begin
    delta = 4'sd0;
    if (!col_first) delta = delta + 4'(slm_pkg::pair_product(spin_up_i, prev_spin_q));
    if (!row_first) delta = delta + 4'(slm_pkg::pair_product(spin_up_i, tail.row_bit));
    if (col_last)   delta = delta + 4'(slm_pkg::pair_product(spin_up_i, first_spin_q));
    if (row_last)   delta = delta + 4'(slm_pkg::pair_product(spin_up_i, tail.first_bit));
    bond_acc_d = bond_acc_q + {{(slm_pkg::BOND_W-4){delta[3]}}, delta};
    spin_acc_d = spin_up_i ? spin_acc_q + slm_pkg::NET_W'(1) : spin_acc_q - slm_pkg::NET_W'(1);
  end

  // Advance counters and sums; hand the frame totals to stage A
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q        <= '0;
      row_q        <= '0;
      prev_spin_q  <= 1'b0;
      first_spin_q <= 1'b0;
      bond_acc_q   <= '0;
      spin_acc_q   <= '0;
      a_valid_q    <= 1'b0;
    end else begin
      if (a_move) begin
        a_valid_q <= 1'b0;
      end
      if (in_fire) begin
        prev_spin_q <= spin_up_i;
        if (col_first) begin
          first_spin_q <= spin_up_i;
        end
        col_q <= col_q + slm_pkg::COL_W'(1);
        if (col_last) begin
          row_q <= row_q + slm_pkg::ROW_W'(1);
        end
        if (last_site) begin
          bond_acc_q <= '0;
          spin_acc_q <= '0;
          a_valid_q  <= 1'b1;
        end else begin
          bond_acc_q <= bond_acc_d;
          spin_acc_q <= spin_acc_d;
        end
      end
    end
  end

  // Hold frame totals in stage A
  always_ff @(posedge clk_i) begin
    if (in_fire && last_site) begin
      a_bond_q <= bond_acc_d;
      a_net_q  <= spin_acc_d;
    end
  end

  // Energy and magnetization from stage A
  always_comb begin
    prod     = slm_pkg::PROD_W'(coupling_q) * slm_pkg::PROD_W'(a_bond_q);
    energy_d = slm_pkg::ENERGY_W'(-prod);
    mag_full = {a_net_q, {slm_pkg::FRAC_BITS{1'b0}}};
    mag_d    = slm_pkg::MAG_W'(mag_full >>> slm_pkg::LOG_SITES);
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (a_move) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_move) begin
      bond_q   <= a_bond_q;
      energy_q <= energy_d;
      net_q    <= a_net_q;
      mag_q    <= mag_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign bond_sum_o      = bond_q;
  assign energy_o        = energy_q;
  assign net_spin_o      = net_q;
  assign magnetization_o = mag_q;

  // Checks
  assign frame_clear = (col_q == '0) && (row_q == '0) && (bond_acc_q == '0) &&
                       (spin_acc_q == '0);
  assign held_back   = a_valid_q && last_site && out_valid_q;

  `SLM_ASSERT_NEXT(a_last_site_loads, in_fire && last_site, a_valid_q, "frame totals not loaded")
  `SLM_ASSERT_NEXT(a_frame_restart, in_fire && last_site, frame_clear, "frame did not restart")
  `SLM_ASSERT(a_stall_cause, !in_ready_o |-> held_back, "input stalled without a waiting result")

endmodule

`default_nettype wire
